@@ hw/rtl/ledscan_pkg.sv @@
// ============================================================================
// ledscan_pkg
// shared types and codes for the led matrix scan driver
// ============================================================================
package ledscan_pkg;

    // scan steps, one per tick
    typedef enum logic [2:0] {
        PH_DATA_LOW,
        PH_DATA_HIGH,
        PH_BLANK,
        PH_LATCH_HIGH,
        PH_LATCH_LOW,
        PH_ADDRESS,
        PH_ENABLE
    } scan_phase_t;

    // item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // color planes
    localparam logic [1:0] COLOR_RED   = 2'd0;
    localparam logic [1:0] COLOR_GREEN = 2'd1;
    localparam logic [1:0] COLOR_BLUE  = 2'd2;

    // one store word holds six bytes: upper r, g, b then lower r, g, b
    localparam int          LANES      = 6;
    localparam int          LANE_BITS  = 8;
    localparam logic [2:0]  LANE_LOWER = 3'd3;

    typedef struct packed {
        logic       kind;
        logic [1:0] color;
        logic [4:0] row;
        logic [2:0] byte_column;
        logic [7:0] byte_value;
    } item_t;

    typedef struct packed {
        logic       red_upper;
        logic       green_upper;
        logic       blue_upper;
        logic       red_lower;
        logic       green_lower;
        logic       blue_lower;
        logic       shift_clock;
        logic       latch;
        logic       output_disable;
        logic [3:0] row_address;
    } result_t;

    // second pipeline stage contents
    typedef struct packed {
        logic       kind;
        logic       wr_ok;
        logic [2:0] lane;
        logic [7:0] byte_value;
        logic [2:0] bit_sel;
        logic       data_en;
        logic       shift_clock;
        logic       latch;
        logic       output_disable;
        logic [3:0] row_address;
    } stage_t;

endpackage

@@ hw/rtl/rgb_led_matrix_scan_driver_unit.sv @@
// ============================================================================
// rgb_led_matrix_scan_driver_unit
// hub75 style 1/16 scan driver with a one bit per color frame store
// ============================================================================
// result path: a tick word's result is registered in stage two and then in the
//   output register before it is on the result port
// throughput: one word per cycle, writes and ticks mixed, unless the result port
//   stalls; set by the single read and single write port of the frame store ram
// reset: scan state returns to the first column, display enabled; the frame
//   store's ROWS/2 * COLUMNS/8 words (128 at the default size) are then cleared
//   one word per cycle, and no word is taken during that sweep
module rgb_led_matrix_scan_driver_unit #(
    parameter int ROWS    = 32,
    parameter int COLUMNS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  ledscan_pkg::item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output ledscan_pkg::result_t result
);

    import ledscan_pkg::*;

    // geometry
    localparam int BPR          = COLUMNS / 8;
    localparam int SCAN_COLUMNS = BPR * 8;
    localparam int HALF_ROWS    = ROWS / 2;
    localparam int DEPTH        = HALF_ROWS * BPR;
    localparam int AW           = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW           = $clog2(SCAN_COLUMNS + 1);
    localparam int RW           = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;
    localparam int WORD_W       = LANES * LANE_BITS;

    // scan state
    scan_phase_t   phase_reg, phase_next;
    logic [CW-1:0] column_reg, column_next, column_inc;
    logic [RW-1:0] scan_row_reg, scan_row_next;
    logic [3:0]    address_reg, address_next;
    logic          blank_reg, blank_next;

    // clearing sweep after reset
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    // stage one (address issue) decode
    logic          accept;
    logic          tick_accept;
    logic          wr_half;
    logic [RW-1:0] wr_pair;
    logic          wr_ok;
    logic [2:0]    wr_lane;
    logic [AW-1:0] s0_addr;
    logic          ctl_clock;
    logic          ctl_latch;
    logic          ctl_data;

    // stage two (read data back, merge or pick bits)
    logic          p1_valid_reg;
    stage_t        p1_reg;
    logic [AW-1:0] p1_addr_reg;
    logic          p1_done;
    logic          p1_wr_en;
    logic [WORD_W-1:0] base_word;
    logic [WORD_W-1:0] merged_word;
    logic [LANES-1:0]  pix;

    // forwarding of a write-back that passes a read of the same entry
    logic              fwd_hit_reg;
    logic [WORD_W-1:0] fwd_data_reg;

    // frame store ram
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    // output register
    logic    result_valid_reg;
    result_t result_reg;

    assign accept      = item_valid && !item_stall;
    assign tick_accept = accept && (item.kind == KIND_TICK);

    // ------------------------------------------------------------------
    // scan sequencer: next state
    // ------------------------------------------------------------------
    assign column_inc = column_reg + 1'b1;

    always_comb
    begin
        phase_next    = phase_reg;
        column_next   = column_reg;
        scan_row_next = scan_row_reg;
        address_next  = address_reg;
        blank_next    = blank_reg;
        if (tick_accept)
        begin
            case (phase_reg)
                PH_DATA_LOW:
                begin
                    phase_next = PH_DATA_HIGH;
                end
                PH_DATA_HIGH:
                begin
                    // column advances on the clock-high step
                    column_next = column_inc;
                    phase_next  = (column_inc >= CW'(SCAN_COLUMNS)) ? PH_BLANK : PH_DATA_LOW;
                end
                PH_BLANK:
                begin
                    blank_next = 1'b1;
                    phase_next = PH_LATCH_HIGH;
                end
                PH_LATCH_HIGH:
                begin
                    phase_next = PH_LATCH_LOW;
                end
                PH_LATCH_LOW:
                begin
                    phase_next = PH_ADDRESS;
                end
                PH_ADDRESS:
                begin
                    address_next = 4'(scan_row_reg);
                    phase_next   = PH_ENABLE;
                end
                PH_ENABLE:
                begin
                    // re-enable and move to the next row pair
                    blank_next    = 1'b0;
                    scan_row_next = (scan_row_reg == RW'(HALF_ROWS - 1)) ?
                                    '0 : scan_row_reg + 1'b1;
                    column_next   = '0;
                    phase_next    = PH_DATA_LOW;
                end
                default:
                begin
                    phase_next = PH_DATA_LOW;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // scan sequencer: pin levels of the current step
    // ------------------------------------------------------------------
    always_comb
    begin
        ctl_clock = 1'b0;
        ctl_latch = 1'b0;
        ctl_data  = 1'b0;
        case (phase_reg)
            PH_DATA_LOW:
            begin
                ctl_data = 1'b1;
            end
            PH_DATA_HIGH:
            begin
                ctl_data  = 1'b1;
                ctl_clock = 1'b1;
            end
            PH_LATCH_HIGH:
            begin
                ctl_latch = 1'b1;
            end
            default:
            begin
                ctl_data = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_DATA_LOW;
            column_reg   <= '0;
            scan_row_reg <= '0;
            address_reg  <= '0;
            blank_reg    <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            column_reg   <= column_next;
            scan_row_reg <= scan_row_next;
            address_reg  <= address_next;
            blank_reg    <= blank_next;
        end
    end

    // ------------------------------------------------------------------
    // write decode: rows r and r + ROWS/2 share one store word
    // ------------------------------------------------------------------
    assign wr_half = int'(item.row) >= HALF_ROWS;
    assign wr_pair = wr_half ? RW'(int'(item.row) - HALF_ROWS) : RW'(item.row);
    assign wr_ok   = (item.color inside {COLOR_RED, COLOR_GREEN, COLOR_BLUE}) &&
                     (int'(item.row) < ROWS) && (int'(item.byte_column) < BPR);
    assign wr_lane = wr_half ? (LANE_LOWER + 3'(item.color)) : 3'(item.color);

    always_comb
    begin
        if (item.kind == KIND_WRITE)
        begin
            s0_addr = AW'(int'(wr_pair) * BPR + int'(item.byte_column));
        end
        else
        begin
            s0_addr = AW'(int'(scan_row_reg) * BPR + int'(column_reg[CW-1:3]));
        end
    end

    // ------------------------------------------------------------------
    // stage two: read-modify-write for writes, bit pick for ticks
    // ------------------------------------------------------------------
    assign base_word = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    always_comb
    begin
        logic [LANE_BITS-1:0] lane_byte;
        lane_byte = '0;
        for (int k = 0; k < LANES; k++)
        begin
            lane_byte = base_word[k*LANE_BITS +: LANE_BITS];
            merged_word[k*LANE_BITS +: LANE_BITS] =
                (3'(k) == p1_reg.lane) ? p1_reg.byte_value : lane_byte;
            // msb is the leftmost column
            pix[k] = p1_reg.data_en & lane_byte[~p1_reg.bit_sel];
        end
    end

    assign p1_wr_en = p1_valid_reg && (p1_reg.kind == KIND_WRITE) && p1_reg.wr_ok;

    // a write always retires; a tick retires once the output register frees
    assign p1_done = p1_valid_reg &&
                     ((p1_reg.kind == KIND_WRITE) || !result_valid_reg || !result_stall);

    assign item_stall = clr_active_reg || (p1_valid_reg && !p1_done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else if (accept)
        begin
            p1_valid_reg <= 1'b1;
            fwd_hit_reg  <= p1_wr_en && (p1_addr_reg == s0_addr);
        end
        else if (p1_done)
        begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_addr_reg           <= s0_addr;
            fwd_data_reg          <= merged_word;
            p1_reg.kind           <= item.kind;
            p1_reg.wr_ok          <= wr_ok;
            p1_reg.lane           <= wr_lane;
            p1_reg.byte_value     <= item.byte_value;
            p1_reg.bit_sel        <= column_reg[2:0];
            p1_reg.data_en        <= ctl_data;
            p1_reg.shift_clock    <= ctl_clock;
            p1_reg.latch          <= ctl_latch;
            p1_reg.output_disable <= blank_next;
            p1_reg.row_address    <= address_next;
        end
    end

    // ------------------------------------------------------------------
    // clearing sweep, one store word per cycle after reset
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // frame store
    // ------------------------------------------------------------------
    assign ram_we    = clr_active_reg || p1_wr_en;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : p1_addr_reg;
    assign ram_wdata = clr_active_reg ? '0 : merged_word;

    ledscan_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (s0_addr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (p1_done && (p1_reg.kind == KIND_TICK))
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_done && (p1_reg.kind == KIND_TICK))
        begin
            result_reg.red_upper      <= pix[0];
            result_reg.green_upper    <= pix[1];
            result_reg.blue_upper     <= pix[2];
            result_reg.red_lower      <= pix[3];
            result_reg.green_lower    <= pix[4];
            result_reg.blue_lower     <= pix[5];
            result_reg.shift_clock    <= p1_reg.shift_clock;
            result_reg.latch          <= p1_reg.latch;
            result_reg.output_disable <= p1_reg.output_disable;
            result_reg.row_address    <= p1_reg.row_address;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // nothing reaches the second stage while the store is being cleared
    a_no_work_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !p1_valid_reg)
        else $error("pipeline busy during clearing sweep");

    // shift clock and latch never high in the same snapshot
    a_clock_latch: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(result_reg.shift_clock && result_reg.latch))
        else $error("shift clock and latch both high");

    // data lines are low during a latch pulse
    a_latch_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.latch) |->
        !(result_reg.red_upper || result_reg.green_upper || result_reg.blue_upper ||
          result_reg.red_lower || result_reg.green_lower || result_reg.blue_lower))
        else $error("data active during latch");

    // the enable step restarts the row at the first column
    a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_accept && (phase_reg == PH_ENABLE)) |=>
        ((column_reg == '0) && (phase_reg == PH_DATA_LOW) && !blank_reg))
        else $error("row restart failed");

endmodule

@@ hw/rtl/ledscan_ram.sv @@
// ============================================================================
// ledscan_ram
// simple dual port ram, one write and one registered read port
// ============================================================================
module ledscan_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
